// ===== hw/rtl/brss_pkg.sv =====
// ----------------------------------------------------------------------------
// brss_pkg
// shared constants and types for the block range sum store
// ----------------------------------------------------------------------------
package brss_pkg;

    localparam int ELEMENTS   = 256;
    localparam int BLOCK_SIZE = 16;
    localparam int NUM_BLOCKS = (ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

    localparam int IDX_W  = 8;
    localparam int BLK_W  = 4;
    localparam int CUR_W  = IDX_W + 1;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        FUNC_UPDATE = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QUERY,
        ST_RESULT
    } state_t;

endpackage

// ===== hw/rtl/block_range_sum_store_top.sv =====
// ----------------------------------------------------------------------------
// block_range_sum_store_top
// element store with per-block running sums, answering range sum queries
// ----------------------------------------------------------------------------
// After reset the block clears both memories before it takes its first
// input beat. An update beat reads (ST_UPD_RD), writes back (ST_UPD_WR) and
// returns to idle, and gives no result. A query walks its range one memory
// read a cycle: single elements up to a block boundary, one block sum per
// whole block of 16, then the trailing elements; then the read pipe drains
// and the result register is loaded once the output is free. The single
// read port of each memory sets the pace of the walk. The next input beat
// is taken while a result still waits in the output register.
module block_range_sum_store_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic        [brss_pkg::IDX_W-1:0]    s_position,
    input  logic signed [brss_pkg::DATA_W-1:0]   s_new_value,
    input  logic        [brss_pkg::IDX_W-1:0]    s_range_low,
    input  logic        [brss_pkg::IDX_W-1:0]    s_range_high,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [brss_pkg::DATA_W-1:0]   m_range_sum
);
    import brss_pkg::*;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] elem_mem [ELEMENTS];
    logic [DATA_W-1:0] blk_mem  [NUM_BLOCKS];

    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CUR_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  hi_reg;
    logic [DATA_W-1:0] acc_reg;
    logic              pend_reg;
    logic              sel_blk_reg;
    logic [DATA_W-1:0] elem_rd_reg;
    logic [DATA_W-1:0] blk_rd_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_sum_reg;

    logic              in_beat;
    logic              out_free;
    logic              issue;
    logic              issue_blk;
    logic              elem_we, blk_we;
    logic [IDX_W-1:0]  elem_waddr, elem_raddr;
    logic [BLK_W-1:0]  blk_waddr, blk_raddr;
    logic [DATA_W-1:0] elem_wdata, blk_wdata;

    assign s_ready     = (state_reg == ST_IDLE);
    assign in_beat     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_sum_reg;

    assign issue     = (state_reg == ST_QUERY) && (cur_reg <= {1'b0, hi_reg});
    assign issue_blk = (cur_reg[BLK_W-1:0] == '0)
                     && ((cur_reg + CUR_W'(BLOCK_SIZE - 1)) <= {1'b0, hi_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == IDX_W'(ELEMENTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    state_next = (func_t'(s_func) == FUNC_QUERY) ? ST_QUERY : ST_UPD_RD;
                end
            end
            ST_UPD_RD: state_next = ST_UPD_WR;
            ST_UPD_WR: state_next = ST_IDLE;
            ST_QUERY: begin
                if (!issue && !pend_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // memory ports
    always_comb begin
        elem_we    = 1'b0;
        blk_we     = 1'b0;
        elem_waddr = pos_reg;
        blk_waddr  = pos_reg[IDX_W-1:IDX_W-BLK_W];
        elem_wdata = val_reg;
        blk_wdata  = blk_rd_reg - elem_rd_reg + val_reg;
        elem_raddr = pos_reg;
        blk_raddr  = pos_reg[IDX_W-1:IDX_W-BLK_W];
        cur_next   = cur_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                elem_we    = 1'b1;
                blk_we     = 1'b1;
                elem_waddr = clr_cnt_reg;
                blk_waddr  = clr_cnt_reg[BLK_W-1:0];
                elem_wdata = '0;
                blk_wdata  = '0;
            end
            ST_IDLE: begin
                if (in_beat) begin
                    cur_next = {1'b0, s_range_low};
                end
            end
            ST_UPD_WR: begin
                elem_we = 1'b1;
                blk_we  = 1'b1;
            end
            ST_QUERY: begin
                elem_raddr = cur_reg[IDX_W-1:0];
                blk_raddr  = cur_reg[IDX_W-1:IDX_W-BLK_W];
                if (issue) begin
                    cur_next = issue_blk ? cur_reg + CUR_W'(BLOCK_SIZE)
                                         : cur_reg + CUR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        elem_rd_reg <= elem_mem[elem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rd_reg <= blk_mem[blk_raddr];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            pend_reg <= issue;
            if (state_reg == ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        sel_blk_reg <= issue_blk;
        cur_reg     <= cur_next;
        if (in_beat) begin
            pos_reg <= s_position;
            val_reg <= s_new_value;
            hi_reg  <= s_range_high;
            acc_reg <= '0;
        end else if (pend_reg) begin
            acc_reg <= acc_reg + (sel_blk_reg ? blk_rd_reg : elem_rd_reg);
        end
        if (state_reg == ST_RESULT && out_free) begin
            m_sum_reg <= acc_reg;
        end
    end

endmodule
